// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file psce_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/psce_pkg.sv =====
`default_nettype none
package psce_pkg;

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_FIND    = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_REMOVE  = 3'd3;
    localparam logic [2:0] OP_AGE     = 3'd4;
    localparam logic [2:0] OP_CLEAR   = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic [2:0] CFG_SIZE_LIMIT    = 3'd0;
    localparam logic [2:0] CFG_GAP_LOG_MAX   = 3'd1;
    localparam logic [2:0] CFG_GAP_LOG_MIN   = 3'd2;
    localparam logic [2:0] CFG_BONUS_STEP    = 3'd3;
    localparam logic [2:0] CFG_NEWBIE_WINDOW = 3'd4;

    localparam logic [3:0] A_NOP      = 4'd0;
    localparam logic [3:0] A_LATCH    = 4'd1;
    localparam logic [3:0] A_DROP_IN  = 4'd2;
    localparam logic [3:0] A_SCAN     = 4'd3;
    localparam logic [3:0] A_ROOM     = 4'd4;
    localparam logic [3:0] A_DROP_VIC = 4'd5;
    localparam logic [3:0] A_INS_WR   = 4'd6;
    localparam logic [3:0] A_GAP_INIT = 4'd7;
    localparam logic [3:0] A_GAP_STEP = 4'd8;
    localparam logic [3:0] A_HIST     = 4'd9;
    localparam logic [3:0] A_SUM      = 4'd10;
    localparam logic [3:0] A_MUL      = 4'd11;
    localparam logic [3:0] A_FIND_WR  = 4'd12;
    localparam logic [3:0] A_REL      = 4'd13;
    localparam logic [3:0] A_CLEAR    = 4'd14;

    localparam logic [1:0] SC_EXPIRE = 2'd0;
    localparam logic [1:0] SC_VICTIM = 2'd1;
    localparam logic [1:0] SC_AGE    = 2'd2;

    localparam logic [15:0] REF_MAX = 16'hFFFF;

    typedef struct packed {
        logic [31:0]        size;
        logic [15:0]        refs;
        logic [47:0]        last_use;
        logic signed [63:0] score;
    } t_rec;

    typedef struct packed {
        logic [3:0] act;
        logic [1:0] mode;
        logic       emit;
        logic       emit_ev;
        logic [1:0] emit_status;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       slot_ok;
        logic       occ_in;
        logic       overwrite;
        logic       out_free;
        logic       scan_done;
        logic       found;
        logic       more;
        logic       gap_run;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/popularity_scored_cache_eviction.sv =====
// Popularity-scored cache eviction controller.
// Input channel: i_in_valid / o_in_stall carry one command (opcode, slot, size,
// overwrite flag, current time, age threshold). A transfer happens on a clock
// edge with valid high and stall low; stall is high while a command is at work.
// Output channel: o_out_valid / i_out_stall carry result items. Each eviction
// gives one result with o_evicted set, and every command ends with one result
// that has o_last set. A finished result sits in an output register, so the
// next command is taken while that result still waits for its transfer.
// Find steps through the arrival gap one bit per cycle, up to gap_log_max.
// Each scan over the records goes through the single read port of the record
// memory. Insert drops the old entry first when it overwrites, and runs one
// victim scan per eviction; evict-older-than runs one scan per removed entry
// and a last one that finds none. The final result becomes valid in the same
// cycle as the input stall drops.
// When the receiver stalls, the controller holds before each result until the
// output register is free. Reset empties the cache, zeroes the total size and
// restores the register defaults; configuration writes take effect at once.
`default_nettype none
module popularity_scored_cache_eviction
    import psce_pkg::*;
#(
    parameter int SLOTS       = 32,
    parameter int HISTORY_LEN = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [4:0]  i_slot,
    input  wire logic [31:0] i_entry_size,
    input  wire logic        i_overwrite,
    input  wire logic [47:0] i_now,
    input  wire logic [47:0] i_max_age,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic             o_evicted,
    output logic [4:0]       o_evicted_slot,
    output logic [47:0]      o_total_size,
    output logic             o_last
);

    t_cmd cmd;
    t_sts sts;
    logic idle;

    assign o_in_stall = !idle;

    psce_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (i_in_valid && idle),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_idle   (idle)
    );

    psce_dp #(
        .SLOTS       (SLOTS),
        .HISTORY_LEN (HISTORY_LEN)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_opcode),
        .i_slot         (i_slot),
        .i_entry_size   (i_entry_size),
        .i_overwrite    (i_overwrite),
        .i_now          (i_now),
        .i_max_age      (i_max_age),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_evicted      (o_evicted),
        .o_evicted_slot (o_evicted_slot),
        .o_total_size   (o_total_size),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire

// ===== rtl/psce_ctrl.sv =====
`default_nettype none
module psce_ctrl
    import psce_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_accept,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_idle
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_DISP      = 5'd1;
    localparam logic [4:0] S_INS_DROP  = 5'd2;
    localparam logic [4:0] S_EXP_START = 5'd3;
    localparam logic [4:0] S_EXP       = 5'd4;
    localparam logic [4:0] S_ROOM      = 5'd5;
    localparam logic [4:0] S_CHK       = 5'd6;
    localparam logic [4:0] S_VIC       = 5'd7;
    localparam logic [4:0] S_EVDROP    = 5'd8;
    localparam logic [4:0] S_EVEMIT    = 5'd9;
    localparam logic [4:0] S_INS_WR    = 5'd10;
    localparam logic [4:0] S_AGE_START = 5'd11;
    localparam logic [4:0] S_AGE       = 5'd12;
    localparam logic [4:0] S_GAP_INIT  = 5'd13;
    localparam logic [4:0] S_GAP       = 5'd14;
    localparam logic [4:0] S_HIST      = 5'd15;
    localparam logic [4:0] S_SUM       = 5'd16;
    localparam logic [4:0] S_MUL       = 5'd17;
    localparam logic [4:0] S_FWR       = 5'd18;
    localparam logic [4:0] S_REL       = 5'd19;
    localparam logic [4:0] S_REM       = 5'd20;
    localparam logic [4:0] S_FIN       = 5'd21;

    logic [4:0] r_state, n_state;
    logic [1:0] r_fin, n_fin;
    logic       r_any, n_any;

    assign o_idle = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fin   <= ST_OK;
            r_any   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
            r_any   <= n_any;
        end
    end

    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        n_any   = r_any;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.act = A_LATCH;
                    n_any     = 1'b0;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_FIN;
                n_fin   = ST_MISS;
                unique case (i_sts.op)
                    OP_INSERT: begin
                        if (!i_sts.slot_ok) begin
                            n_fin = ST_FULL;
                        end else if (i_sts.occ_in && !i_sts.overwrite) begin
                            n_fin = ST_DUP;
                        end else if (i_sts.occ_in) begin
                            n_state = S_INS_DROP;
                        end else begin
                            n_state = S_EXP_START;
                        end
                    end
                    OP_FIND: begin
                        if (i_sts.occ_in) n_state = S_GAP_INIT;
                    end
                    OP_RELEASE: begin
                        if (i_sts.occ_in) n_state = S_REL;
                    end
                    OP_REMOVE: begin
                        if (i_sts.occ_in) n_state = S_REM;
                    end
                    OP_AGE: begin
                        n_state = S_AGE_START;
                    end
                    OP_CLEAR: begin
                        o_cmd.act = A_CLEAR;
                        n_fin     = ST_OK;
                    end
                    default: begin
                        n_fin = ST_MISS;
                    end
                endcase
            end
            S_INS_DROP: begin
                o_cmd.act = A_DROP_IN;
                n_state   = S_EXP_START;
            end
            S_EXP_START: begin
                o_cmd.act  = A_SCAN;
                o_cmd.mode = SC_EXPIRE;
                n_state    = S_EXP;
            end
            S_EXP: begin
                if (i_sts.scan_done) n_state = S_ROOM;
            end
            S_ROOM: begin
                o_cmd.act = A_ROOM;
                n_state   = S_CHK;
            end
            S_CHK: begin
                if (i_sts.more) begin
                    o_cmd.act  = A_SCAN;
                    o_cmd.mode = SC_VICTIM;
                    n_state    = S_VIC;
                end else begin
                    n_state = S_INS_WR;
                end
            end
            S_VIC: begin
                if (i_sts.scan_done) begin
                    if (i_sts.found) begin
                        n_state = S_EVDROP;
                    end else begin
                        n_fin   = ST_FULL;
                        n_state = S_FIN;
                    end
                end
            end
            S_EVDROP: begin
                o_cmd.act = A_DROP_VIC;
                n_state   = S_EVEMIT;
            end
            S_EVEMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_ev     = 1'b1;
                    o_cmd.emit_status = ST_OK;
                    n_any             = 1'b1;
                    n_state = (i_sts.op == OP_INSERT) ? S_CHK : S_AGE_START;
                end
            end
            S_INS_WR: begin
                o_cmd.act = A_INS_WR;
                n_fin     = ST_OK;
                n_state   = S_FIN;
            end
            S_AGE_START: begin
                o_cmd.act  = A_SCAN;
                o_cmd.mode = SC_AGE;
                n_state    = S_AGE;
            end
            S_AGE: begin
                if (i_sts.scan_done) begin
                    if (i_sts.found) begin
                        n_state = S_EVDROP;
                    end else begin
                        n_fin   = r_any ? ST_OK : ST_MISS;
                        n_state = S_FIN;
                    end
                end
            end
            S_GAP_INIT: begin
                o_cmd.act = A_GAP_INIT;
                n_state   = S_GAP;
            end
            S_GAP: begin
                if (i_sts.gap_run) begin
                    o_cmd.act = A_GAP_STEP;
                end else begin
                    n_state = S_HIST;
                end
            end
            S_HIST: begin
                o_cmd.act = A_HIST;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.act = A_SUM;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.act = A_MUL;
                n_state   = S_FWR;
            end
            S_FWR: begin
                o_cmd.act = A_FIND_WR;
                n_fin     = ST_OK;
                n_state   = S_FIN;
            end
            S_REL: begin
                o_cmd.act = A_REL;
                n_fin     = ST_OK;
                n_state   = S_FIN;
            end
            S_REM: begin
                o_cmd.act = A_DROP_IN;
                n_fin     = ST_OK;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = r_fin;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/psce_dp.sv =====
`default_nettype none
module psce_dp
    import psce_pkg::*;
#(
    parameter int SLOTS       = 32,
    parameter int HISTORY_LEN = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [4:0]  i_slot,
    input  wire logic [31:0] i_entry_size,
    input  wire logic        i_overwrite,
    input  wire logic [47:0] i_now,
    input  wire logic [47:0] i_max_age,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic             o_evicted,
    output logic [4:0]       o_evicted_slot,
    output logic [47:0]      o_total_size,
    output logic             o_last
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [47:0] r_size_limit;
    logic [5:0]  r_gmax;
    logic [5:0]  r_gmin;
    logic [39:0] r_bonus;
    logic [47:0] r_window;

    logic [2:0]  r_op;
    logic [4:0]  r_slot;
    logic [31:0] r_esize;
    logic        r_ow;
    logic [47:0] r_now;
    logic [47:0] r_maxage;

    logic [SLOTS-1:0] r_occ;
    logic [SLOTS-1:0] r_newb;
    logic [47:0]      r_sum;

    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic             r_out_ev;
    logic [4:0]       r_out_slot;
    logic [47:0]      r_out_total;
    logic             r_out_last;

    t_rec rec_mem [SLOTS];
    logic [HISTORY_LEN-1:0][5:0] hist_mem [SLOTS];
    logic [HISTORY_LEN-1:0][7:0] cnt_mem  [SLOTS];
    t_rec                        r_rd;
    logic [HISTORY_LEN-1:0][5:0] r_hist_rd;
    logic [HISTORY_LEN-1:0][7:0] r_cnt_rd;

    logic                     r_scan_on;
    logic [1:0]               r_scan_mode;
    logic [CW-1:0]            r_idx;
    logic                     r_cmp_vld;
    logic [SW-1:0]            r_cmp_idx;
    logic                     r_found;
    logic [1:0]               r_bcat;
    logic signed [63:0]       r_bscore;
    logic signed [48:0]       r_best;
    logic [SW-1:0]            r_vic;
    logic [31:0]              r_vic_size;

    logic [48:0] r_room;
    logic [48:0] r_freed;

    logic [47:0]                 r_diff;
    logic [5:0]                  r_g;
    logic [HISTORY_LEN-1:0][5:0] r_hist_w;
    logic [HISTORY_LEN-1:0][7:0] r_cnt_w;
    logic signed [9:0]           r_delta;
    logic signed [50:0]          r_prod;

    logic [6:0]    slot7;
    logic          slot_ok;
    logic [SW-1:0] s_addr;
    logic [SW-1:0] rd_addr;
    logic          issue;
    logic          scan_done;

    logic               c_occ;
    logic               c_newb;
    logic signed [48:0] c_age;
    logic [1:0]         c_cat;
    logic               c_better;
    logic               c_old;
    logic               exp_hit;
    logic signed [48:0] g_age;
    logic [48:0]        tot;

    logic                        rec_we;
    logic [SW-1:0]               rec_waddr;
    t_rec                        rec_wdata;
    logic                        hist_we;
    logic [HISTORY_LEN-1:0][5:0] hist_wdata;
    logic [HISTORY_LEN-1:0][7:0] cnt_wdata;
    logic [HISTORY_LEN-1:0][5:0] hist_upd;
    logic [HISTORY_LEN-1:0][7:0] cnt_upd;
    logic [HISTORY_LEN-1:0][7:0] cnt_init;
    logic [8:0]                  hsum;
    logic [15:0]                 find_ref;
    logic [6:0]                  vic7;

    assign slot7   = {2'b00, r_slot};
    assign slot_ok = slot7 < 7'(SLOTS);
    assign s_addr  = slot7[SW-1:0];
    assign rd_addr = r_scan_on ? r_idx[SW-1:0] : s_addr;
    assign issue     = r_scan_on && (r_idx != CW'(SLOTS));
    assign scan_done = r_scan_on && !issue && !r_cmp_vld;

    assign c_occ  = r_occ[r_cmp_idx];
    assign c_newb = r_newb[r_cmp_idx];
    assign c_age  = $signed({1'b0, r_now}) - $signed({1'b0, r_rd.last_use});
    assign c_cat  = c_newb ? 2'd1 : ((r_rd.refs == 16'd0) ? 2'd0 : 2'd2);
    assign c_better = !r_found || (c_cat < r_bcat) ||
                      ((c_cat == r_bcat) && (r_rd.score < r_bscore));
    assign c_old  = (c_age >= $signed({1'b0, r_maxage})) && (c_age > r_best);
    assign exp_hit = r_cmp_vld && (r_scan_mode == SC_EXPIRE) && c_occ && c_newb &&
                     (c_age > $signed({1'b0, r_window}));
    assign g_age  = $signed({1'b0, r_now}) - $signed({1'b0, r_rd.last_use});
    assign tot    = {1'b0, r_sum} + {17'd0, r_esize};

    assign vic7 = 7'(r_vic);

    always_comb begin
        for (int i = 0; i < HISTORY_LEN; i++) begin
            cnt_init[i] = 8'(1) << i;
            if ((r_cnt_rd[i] - 8'd1) == 8'd0) begin
                cnt_upd[i]  = cnt_init[i];
                hist_upd[i] = (i == 0) ? r_g : r_hist_rd[(i == 0) ? 0 : i - 1];
            end else begin
                cnt_upd[i]  = r_cnt_rd[i] - 8'd1;
                hist_upd[i] = r_hist_rd[i];
            end
        end
        hsum = '0;
        for (int i = 0; i < HISTORY_LEN; i++) begin
            hsum = hsum + {3'd0, r_hist_w[i]};
        end
    end

    always_comb begin
        if (r_newb[s_addr]) begin
            find_ref = 16'd1;
        end else if (r_rd.refs < REF_MAX) begin
            find_ref = r_rd.refs + 16'd1;
        end else begin
            find_ref = r_rd.refs;
        end
    end

    always_comb begin
        rec_we     = 1'b0;
        rec_waddr  = s_addr;
        rec_wdata  = r_rd;
        hist_we    = 1'b0;
        hist_wdata = r_hist_w;
        cnt_wdata  = r_cnt_w;
        priority if (exp_hit) begin
            rec_we         = 1'b1;
            rec_waddr      = r_cmp_idx;
            rec_wdata.refs = 16'd0;
        end else if (i_cmd.act == A_INS_WR) begin
            rec_we             = 1'b1;
            rec_wdata.size     = r_esize;
            rec_wdata.refs     = 16'd0;
            rec_wdata.last_use = r_now;
            rec_wdata.score    = $signed({16'd0, r_now});
            hist_we            = 1'b1;
            for (int i = 0; i < HISTORY_LEN; i++) begin
                hist_wdata[i] = r_gmax;
                cnt_wdata[i]  = cnt_init[i];
            end
        end else if (i_cmd.act == A_FIND_WR) begin
            rec_we             = 1'b1;
            rec_wdata.refs     = find_ref;
            rec_wdata.last_use = r_now;
            rec_wdata.score    = $signed({16'd0, r_now}) +
                                 $signed({{13{r_prod[50]}}, r_prod});
            hist_we            = 1'b1;
        end else if (i_cmd.act == A_REL) begin
            rec_we         = 1'b1;
            rec_wdata.refs = (r_newb[s_addr] || (r_rd.refs == 16'd0)) ? 16'd0
                                                                       : r_rd.refs - 16'd1;
        end else begin
            rec_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rec_we) rec_mem[rec_waddr] <= rec_wdata;
        r_rd <= rec_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            hist_mem[s_addr] <= hist_wdata;
            cnt_mem[s_addr]  <= cnt_wdata;
        end
        r_hist_rd <= hist_mem[rd_addr];
        r_cnt_rd  <= cnt_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_limit <= 48'd0;
            r_gmax       <= 6'd37;
            r_gmin       <= 6'd21;
            r_bonus      <= 40'd0;
            r_window     <= 48'd0;
            r_occ        <= '0;
            r_newb       <= '0;
            r_sum        <= 48'd0;
            r_out_valid  <= 1'b0;
            r_scan_on    <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_found      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_SIZE_LIMIT:    r_size_limit <= i_cfg_data;
                    CFG_GAP_LOG_MAX:   r_gmax       <= i_cfg_data[5:0];
                    CFG_GAP_LOG_MIN:   r_gmin       <= i_cfg_data[5:0];
                    CFG_BONUS_STEP:    r_bonus      <= i_cfg_data[39:0];
                    CFG_NEWBIE_WINDOW: r_window     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.act == A_SCAN) begin
                r_scan_on <= 1'b1;
                r_cmp_vld <= 1'b0;
                r_found   <= 1'b0;
            end else if (r_scan_on) begin
                r_cmp_vld <= issue;
                if (scan_done) r_scan_on <= 1'b0;
            end

            if (r_cmp_vld && c_occ) begin
                if ((r_scan_mode == SC_VICTIM && c_better) ||
                    (r_scan_mode == SC_AGE && c_old)) begin
                    r_found <= 1'b1;
                end
            end
            if (exp_hit) r_newb[r_cmp_idx] <= 1'b0;

            unique case (i_cmd.act)
                A_DROP_IN: begin
                    r_occ[s_addr]  <= 1'b0;
                    r_newb[s_addr] <= 1'b0;
                    r_sum          <= r_sum - {16'd0, r_rd.size};
                end
                A_DROP_VIC: begin
                    r_occ[r_vic]  <= 1'b0;
                    r_newb[r_vic] <= 1'b0;
                    r_sum         <= r_sum - {16'd0, r_vic_size};
                end
                A_INS_WR: begin
                    r_occ[s_addr]  <= 1'b1;
                    r_newb[s_addr] <= 1'b1;
                    r_sum          <= tot[47:0];
                end
                A_FIND_WR: begin
                    r_newb[s_addr] <= 1'b0;
                end
                A_REL: begin
                    if (r_newb[s_addr] || (r_rd.refs == 16'd0)) r_newb[s_addr] <= 1'b0;
                end
                A_CLEAR: begin
                    r_occ  <= '0;
                    r_newb <= '0;
                    r_sum  <= 48'd0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.act == A_LATCH) begin
            r_op     <= i_opcode;
            r_slot   <= i_slot;
            r_esize  <= i_entry_size;
            r_ow     <= i_overwrite;
            r_now    <= i_now;
            r_maxage <= i_max_age;
        end

        if (i_cmd.emit) begin
            r_out_status <= i_cmd.emit_status;
            r_out_ev     <= i_cmd.emit_ev;
            r_out_slot   <= i_cmd.emit_ev ? vic7[4:0] : 5'd0;
            r_out_total  <= r_sum;
            r_out_last   <= !i_cmd.emit_ev;
        end

        if (i_cmd.act == A_SCAN) begin
            r_scan_mode <= i_cmd.mode;
            r_idx       <= '0;
            r_best      <= '0;
        end else if (issue) begin
            r_idx     <= r_idx + CW'(1);
            r_cmp_idx <= r_idx[SW-1:0];
        end

        if (r_cmp_vld && c_occ) begin
            if (r_scan_mode == SC_VICTIM && c_better) begin
                r_bcat     <= c_cat;
                r_bscore   <= r_rd.score;
                r_vic      <= r_cmp_idx;
                r_vic_size <= r_rd.size;
            end else if (r_scan_mode == SC_AGE && c_old) begin
                r_best     <= c_age;
                r_vic      <= r_cmp_idx;
                r_vic_size <= r_rd.size;
            end
        end

        unique case (i_cmd.act)
            A_ROOM: begin
                r_room  <= (tot > {1'b0, r_size_limit}) ? tot - {1'b0, r_size_limit}
                                                        : 49'd0;
                r_freed <= 49'd0;
            end
            A_DROP_VIC: begin
                r_freed <= r_freed + {17'd0, r_vic_size};
            end
            A_GAP_INIT: begin
                r_diff <= (!g_age[48] && (g_age != 49'sd0)) ? g_age[47:0] : 48'd0;
                r_g    <= 6'd0;
            end
            A_GAP_STEP: begin
                r_diff <= r_diff >> 1;
                r_g    <= r_g + 6'd1;
            end
            A_HIST: begin
                if (r_g >= r_gmin) begin
                    r_hist_w <= hist_upd;
                    r_cnt_w  <= cnt_upd;
                end else begin
                    r_hist_w <= r_hist_rd;
                    r_cnt_w  <= r_cnt_rd;
                end
            end
            A_SUM: begin
                r_delta <= $signed(10'({4'd0, r_gmax} * 10'(HISTORY_LEN)) - {1'b0, hsum});
            end
            A_MUL: begin
                r_prod <= $signed({1'b0, r_bonus}) * r_delta;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.op        = r_op;
    assign o_sts.slot_ok   = slot_ok;
    assign o_sts.occ_in    = slot_ok && r_occ[s_addr];
    assign o_sts.overwrite = r_ow;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_sts.scan_done = scan_done;
    assign o_sts.found     = r_found;
    assign o_sts.more      = r_room > r_freed;
    assign o_sts.gap_run   = (r_diff != 48'd0) && (r_g < r_gmax);

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_evicted      = r_out_ev;
    assign o_evicted_slot = r_out_slot;
    assign o_total_size   = r_out_total;
    assign o_last         = r_out_last;

endmodule
`default_nettype wire

// ===== rtl/psce_chk.sv =====
`default_nettype none
`include "assert_macros.svh"
module psce_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_status,
    input wire logic        o_evicted,
    input wire logic [47:0] o_total_size,
    input wire logic        o_last
);

    `CHK_NEXT(a_busy_after_cmd, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input not stalled after a command transfer")
    `CHK_SAME(a_evict_not_last, i_clk, i_rst_n, o_out_valid && o_evicted, !o_last && (o_status == 2'd0), "eviction result marked last or not ok")
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_total_size), "stalled result dropped or changed")

endmodule

bind popularity_scored_cache_eviction psce_chk u_chk (.*);
`default_nettype wire
